[rtl/ketr_pkg.sv]
// shared types and constants for the key edge and typematic repeat block
// no dependencies; imported by every module under rtl/

package ketr_pkg;

  localparam int NUM_CMD    = 6;
  localparam int NUM_DIRS   = 4;
  localparam int NUM_DIGITS = 5;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int TAB_W      = 3;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CFG_W-1:0] DELAY_RST    = 16'd350;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd50;

  // register select, taken from paddr bit 2
  localparam logic REG_DELAY    = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  localparam int CMD_ESCAPE = 0;

  typedef struct packed {
    logic              accept;
    logic              clear;
    logic [TIME_W-1:0] now;
    logic [CFG_W-1:0]  delay;
    logic [CFG_W-1:0]  interval;
  } lane_ctl_t;

  typedef struct packed {
    logic pulse;
    logic held;
  } lane_sts_t;

  typedef struct packed {
    logic [NUM_CMD-1:0]  cmd;
    logic [NUM_DIRS-1:0] dir;
    logic [TAB_W-1:0]    tab;
  } res_t;

endpackage

[rtl/ketr_lane.sv]
// one typematic lane: press pulse, hold delay and repeat interval for one key
// depends on ketr_pkg

module ketr_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               level,
  input  ketr_pkg::lane_ctl_t ctl,
  output ketr_pkg::lane_sts_t sts
);
  import ketr_pkg::*;

  logic              held_r, held_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] since_start, since_last;
  logic              pulse;

  // modular elapsed times
  assign since_start = ctl.now - start_r;
  assign since_last  = ctl.now - last_r;

  always_comb begin
    held_nxt  = held_r;
    start_nxt = start_r;
    last_nxt  = last_r;
    pulse     = 1'b0;
    if (ctl.clear || !level) begin
      held_nxt = 1'b0;
    end else if (!held_r) begin
      held_nxt  = 1'b1;
      start_nxt = ctl.now;
      last_nxt  = ctl.now;
      pulse     = 1'b1;
    end else if (since_start < {{(TIME_W-CFG_W){1'b0}}, ctl.delay}) begin
      pulse = 1'b0;
    end else if (since_last < {{(TIME_W-CFG_W){1'b0}}, ctl.interval}) begin
      pulse = 1'b0;
    end else begin
      last_nxt = ctl.now;
      pulse    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (ctl.accept) begin
      held_r <= held_nxt;
    end
  end

  // times only matter while held, so no reset
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      start_r <= start_nxt;
      last_r  <= last_nxt;
    end
  end

  assign sts.pulse = pulse;
  assign sts.held  = held_r;

endmodule

[rtl/ketr_merge.sv]
// merge stage: command edges, tab choice and lane pulses under the mode masks
// depends on ketr_pkg

module ketr_merge (
  input  logic [ketr_pkg::NUM_CMD-1:0]    cmd,
  input  logic [ketr_pkg::NUM_DIGITS-1:0] dig,
  input  logic [ketr_pkg::NUM_CMD-1:0]    prev_cmd,
  input  logic [ketr_pkg::NUM_DIGITS-1:0] prev_dig,
  input  logic                            text_mode,
  input  logic                            blocked,
  input  logic [ketr_pkg::NUM_DIRS-1:0]   lane_pulse,
  output ketr_pkg::res_t                  res
);
  import ketr_pkg::*;

  logic [NUM_CMD-1:0]    cmd_rise;
  logic [NUM_DIGITS-1:0] dig_rise;
  logic [TAB_W-1:0]      tab;

  assign cmd_rise = cmd & ~prev_cmd;
  assign dig_rise = dig & ~prev_dig;

  // highest newly pressed digit wins
  always_comb begin
    tab = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (dig_rise[k]) tab = TAB_W'(k + 1);
    end
  end

  always_comb begin
    res = '0;
    if (!blocked) begin
      res.cmd[CMD_ESCAPE] = cmd_rise[CMD_ESCAPE];
      if (!text_mode) begin
        res.cmd = cmd_rise;
        res.dir = lane_pulse;
        res.tab = tab;
      end
    end
  end

endmodule

[rtl/key_edge_and_typematic_repeat.sv]
// top level: config registers, four typematic lanes, merge and output skid
// depends on ketr_pkg, ketr_lane and ketr_merge

// One poll of the key levels per word, accepted whenever in_stall is low: the four
// direction lanes and the merge finish a word in the accepting cycle and the result
// is registered in the output register, or in the skid while the output register
// holds a result not taken; the sustained rate is one word per clock while in_stall
// stays low. The rate is set by the lane update, two 32-bit modular subtracts and
// compares. A two-entry output stage (output register plus skid) lets a new word in
// while a result waits; in_stall rises only when both entries are full. Write
// repeat_delay_ms at byte 0 and repeat_interval_ms at byte 4 while idle.
module key_edge_and_typematic_repeat (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ketr_pkg::ADDR_W-1:0]     paddr,
  input  logic [ketr_pkg::DATA_W-1:0]     pwdata,
  output logic [ketr_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  // poll input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ketr_pkg::NUM_CMD-1:0]    in_command_keys,
  input  logic [ketr_pkg::NUM_DIRS-1:0]   in_direction_keys,
  input  logic [ketr_pkg::NUM_DIGITS-1:0] in_digit_keys,
  input  logic                            in_text_mode,
  input  logic                            in_blocked,
  input  logic [ketr_pkg::TIME_W-1:0]     in_now_ms,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ketr_pkg::NUM_CMD-1:0]    out_command_pulses,
  output logic [ketr_pkg::NUM_DIRS-1:0]   out_direction_pulses,
  output logic [ketr_pkg::TAB_W-1:0]      out_tab_choice
);
  import ketr_pkg::*;

  logic [CFG_W-1:0]      delay_r, interval_r;
  logic [NUM_CMD-1:0]    prev_cmd_r;
  logic [NUM_DIGITS-1:0] prev_dig_r;
  logic                  out_valid_r, skid_valid_r;
  res_t                  out_r, skid_r, res;
  lane_ctl_t             lane_ctl;
  lane_sts_t [NUM_DIRS-1:0] lane_sts;
  logic [NUM_DIRS-1:0]   lane_pulse;
  logic                  cfg_wr, acc, take;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r    <= DELAY_RST;
      interval_r <= INTERVAL_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DELAY:    delay_r    <= pwdata[CFG_W-1:0];
        REG_INTERVAL: interval_r <= pwdata[CFG_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DELAY:    prdata = {{(DATA_W-CFG_W){1'b0}}, delay_r};
      REG_INTERVAL: prdata = {{(DATA_W-CFG_W){1'b0}}, interval_r};
      default:      prdata = '0;
    endcase
  end

  // handshake
  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;
  assign take     = out_valid_r && !out_stall;

  assign lane_ctl.accept   = acc;
  assign lane_ctl.clear    = in_text_mode || in_blocked;
  assign lane_ctl.now      = in_now_ms;
  assign lane_ctl.delay    = delay_r;
  assign lane_ctl.interval = interval_r;

  for (genvar g = 0; g < NUM_DIRS; g++) begin : g_lane
    ketr_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .level (in_direction_keys[g]),
      .ctl   (lane_ctl),
      .sts   (lane_sts[g])
    );
    assign lane_pulse[g] = lane_sts[g].pulse;
  end

  ketr_merge u_merge (
    .cmd        (in_command_keys),
    .dig        (in_digit_keys),
    .prev_cmd   (prev_cmd_r),
    .prev_dig   (prev_dig_r),
    .text_mode  (in_text_mode),
    .blocked    (in_blocked),
    .lane_pulse (lane_pulse),
    .res        (res)
  );

  // previous levels are kept whatever the mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cmd_r <= '0;
      prev_dig_r <= '0;
    end else if (acc) begin
      prev_cmd_r <= in_command_keys;
      prev_dig_r <= in_digit_keys;
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) skid_valid_r <= 1'b0;
    end else if (acc) begin
      if (out_valid_r && !take) skid_valid_r <= 1'b1;
      else                      out_valid_r  <= 1'b1;
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) out_r <= skid_r;
    end else if (acc) begin
      if (out_valid_r && !take) skid_r <= res;
      else                      out_r  <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_command_pulses   = out_r.cmd;
  assign out_direction_pulses = out_r.dir;
  assign out_tab_choice       = out_r.tab;

`ifndef SYNTHESIS
  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without output word");

  // a blocked or text-mode word drops every lane's hold
  a_mode_clears_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_blocked || in_text_mode)) |=>
      !lane_sts[0].held && !lane_sts[1].held && !lane_sts[2].held && !lane_sts[3].held)
    else $error("repeat state survived blocked or text mode");

  // a press after release always pulses at once
  a_press_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_blocked && !in_text_mode && in_direction_keys[0] && !lane_sts[0].held)
      |-> res.dir[0])
    else $error("first press of a direction key gave no pulse");

  // tab choice stays in the digit range
  a_tab_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.tab <= TAB_W'(NUM_DIGITS)))
    else $error("tab choice out of range");
`endif

endmodule

[dv/ketr_pulse_checker.sv]
// pulse checker for key_edge_and_typematic_repeat: watches the poll, result and apb ports,
// predicts each result word and compares; depends on ketr_pkg only
module ketr_pulse_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [ketr_pkg::ADDR_W-1:0]     paddr,
  input  logic [ketr_pkg::DATA_W-1:0]     pwdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [ketr_pkg::NUM_CMD-1:0]    in_command_keys,
  input  logic [ketr_pkg::NUM_DIRS-1:0]   in_direction_keys,
  input  logic [ketr_pkg::NUM_DIGITS-1:0] in_digit_keys,
  input  logic                            in_text_mode,
  input  logic                            in_blocked,
  input  logic [ketr_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [ketr_pkg::NUM_CMD-1:0]    out_command_pulses,
  input  logic [ketr_pkg::NUM_DIRS-1:0]   out_direction_pulses,
  input  logic [ketr_pkg::TAB_W-1:0]      out_tab_choice,
  output int                              outstanding,
  output int                              failures
);
  timeunit 1ns;
  timeprecision 1ps;
  import ketr_pkg::*;

  logic [CFG_W-1:0]      delay_ms;
  logic [CFG_W-1:0]      interval_ms;
  logic [NUM_CMD-1:0]    last_cmd;
  logic [NUM_DIGITS-1:0] last_dig;
  logic [NUM_DIRS-1:0]   held;
  logic [TIME_W-1:0]     press_ms [NUM_DIRS];
  logic [TIME_W-1:0]     pulse_ms [NUM_DIRS];
  res_t                  expected_pulses [$];
  int                    fail_cnt = 0;

  function automatic void drop_repeat(input int k);
    held[k]     = 1'b0;
    press_ms[k] = '0;
    pulse_ms[k] = '0;
  endfunction

  // one poll through the key logic, updating the held state
  function automatic res_t predict_pulses(input logic [NUM_CMD-1:0] cmd,
                                          input logic [NUM_DIRS-1:0] dir,
                                          input logic [NUM_DIGITS-1:0] dig,
                                          input logic text, input logic blk,
                                          input logic [TIME_W-1:0] now);
    res_t                  r;
    logic [NUM_CMD-1:0]    cmd_rise;
    logic [NUM_DIGITS-1:0] dig_rise;
    int                    k;
    r        = '0;
    cmd_rise = cmd & ~last_cmd;
    dig_rise = dig & ~last_dig;
    if (!blk && text) r.cmd[CMD_ESCAPE] = cmd_rise[CMD_ESCAPE];
    if (!blk && !text) begin
      r.cmd = cmd_rise;
      for (k = 0; k < NUM_DIRS; k++) begin
        if (!dir[k]) begin
          drop_repeat(k);
        end else if (!held[k]) begin
          held[k]     = 1'b1;
          press_ms[k] = now;
          pulse_ms[k] = now;
          r.dir[k]    = 1'b1;
        end else if ((now - press_ms[k]) >= {16'b0, delay_ms} &&
                     (now - pulse_ms[k]) >= {16'b0, interval_ms}) begin
          pulse_ms[k] = now;
          r.dir[k]    = 1'b1;
        end
      end
      for (k = 0; k < NUM_DIGITS; k++)
        if (dig_rise[k]) r.tab = TAB_W'(k + 1);
    end else begin
      for (k = 0; k < NUM_DIRS; k++) drop_repeat(k);
    end
    last_cmd = cmd;
    last_dig = dig;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    int   k;
    if (!rst_n) begin
      delay_ms    = DELAY_RST;
      interval_ms = INTERVAL_RST;
      last_cmd    = '0;
      last_dig    = '0;
      for (k = 0; k < NUM_DIRS; k++) drop_repeat(k);
      expected_pulses.delete();
    end else begin
      // result side first: a word leaving now came from an earlier poll
      if (out_valid && !out_stall) begin
        got.cmd = out_command_pulses;
        got.dir = out_direction_pulses;
        got.tab = out_tab_choice;
        if (expected_pulses.size() == 0) begin
          $error("result word with no poll waiting");
          fail_cnt++;
        end else begin
          want = expected_pulses.pop_front();
          if (got.cmd !== want.cmd) begin
            $error("command_pulses expected %h got %h", want.cmd, got.cmd);
            fail_cnt++;
          end
          if (got.dir !== want.dir) begin
            $error("direction_pulses expected %h got %h", want.dir, got.dir);
            fail_cnt++;
          end
          if (got.tab !== want.tab) begin
            $error("tab_choice expected %0d got %0d", want.tab, got.tab);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_pulses.push_back(predict_pulses(in_command_keys, in_direction_keys,
                                                 in_digit_keys, in_text_mode,
                                                 in_blocked, in_now_ms));
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_DELAY:    delay_ms    = pwdata[CFG_W-1:0];
          REG_INTERVAL: interval_ms = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_pulses.size();
    failures    <= fail_cnt;
  end

endmodule

[dv/key_edge_and_typematic_repeat_tb.sv]
// top of the key_edge_and_typematic_repeat testbench: clock, reset, apb writes,
// poll stimulus and stall pattern; checking lives in ketr_pulse_checker
module key_edge_and_typematic_repeat_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ketr_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int NUM_PHASES      = 8;
  localparam int POLLS_PER_PHASE = 225;

  logic                  clk;
  logic                  rst_n                = 1'b0;
  logic                  psel                 = 1'b0;
  logic                  penable              = 1'b0;
  logic                  pwrite               = 1'b0;
  logic [ADDR_W-1:0]     paddr                = '0;
  logic [DATA_W-1:0]     pwdata               = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid             = 1'b0;
  logic                  in_stall;
  logic [NUM_CMD-1:0]    in_command_keys      = '0;
  logic [NUM_DIRS-1:0]   in_direction_keys    = '0;
  logic [NUM_DIGITS-1:0] in_digit_keys        = '0;
  logic                  in_text_mode         = 1'b0;
  logic                  in_blocked           = 1'b0;
  logic [TIME_W-1:0]     in_now_ms            = '0;
  logic                  out_valid;
  logic                  out_stall            = 1'b0;
  logic [NUM_CMD-1:0]    out_command_pulses;
  logic [NUM_DIRS-1:0]   out_direction_pulses;
  logic [TAB_W-1:0]      out_tab_choice;

  int   outstanding;
  int   failures;
  int   cycles;
  logic src_idle  = 1'b1;
  logic sink_idle = 1'b1;

  key_edge_and_typematic_repeat DUT (.*);

  ketr_pulse_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .pready               (pready),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command_keys      (in_command_keys),
    .in_direction_keys    (in_direction_keys),
    .in_digit_keys        (in_digit_keys),
    .in_text_mode         (in_text_mode),
    .in_blocked           (in_blocked),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_command_pulses   (out_command_pulses),
    .out_direction_pulses (out_direction_pulses),
    .out_tab_choice       (out_tab_choice),
    .outstanding          (outstanding),
    .failures             (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("key_edge_and_typematic_repeat verification failed");
    $finish;
  end

  // result side: random stall before each word while sink_idle is set
  initial begin
    int hold;
    forever begin
      hold = sink_idle ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_poll(input logic [NUM_CMD-1:0] cmd, input logic [NUM_DIRS-1:0] dir,
                           input logic [NUM_DIGITS-1:0] dig, input logic text,
                           input logic blk, input logic [TIME_W-1:0] now);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command_keys   <= cmd;
    in_direction_keys <= dir;
    in_digit_keys     <= dig;
    in_text_mode      <= text;
    in_blocked        <= blk;
    in_now_ms         <= now;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the poll side until every result word is out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {(DATA_W-CFG_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // mostly held keys with slow bit flips and time steps scaled to the settings
  task automatic random_polls(input int count, input logic [CFG_W-1:0] delay_v,
                              input logic [CFG_W-1:0] interval_v);
    logic [NUM_CMD-1:0]    cmd;
    logic [NUM_DIRS-1:0]   dir;
    logic [NUM_DIGITS-1:0] dig;
    logic [TIME_W-1:0]     stamp;
    int                    pick;
    int                    n;
    cmd   = '0;
    dir   = '0;
    dig   = '0;
    stamp = $urandom_range(0, 1) ? $urandom : 32'hFFFF_F000 + $urandom_range(0, 4095);
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_poll(NUM_CMD'($urandom), NUM_DIRS'($urandom), NUM_DIGITS'($urandom),
                  1'($urandom), 1'($urandom), $urandom);
      end else begin
        cmd ^= NUM_CMD'($urandom & $urandom & $urandom);
        dir ^= NUM_DIRS'($urandom & $urandom & $urandom & $urandom);
        dig ^= NUM_DIGITS'($urandom & $urandom & $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)      stamp += $urandom_range(0, delay_v / 8 + 4);
        else if (pick < 80) stamp += $urandom_range(0, interval_v + 4);
        else if (pick < 95) stamp += $urandom_range(0, 1000);
        else                stamp += $urandom;
        send_poll(cmd, dir, dig, $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
                  stamp);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] delay_v;
    logic [CFG_W-1:0] interval_v;
    int               phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // defaults 350 / 50
    send_poll('0, '0, '0, 1'b0, 1'b0, 32'd0);
    send_poll(6'h3F, 4'hF, 5'h1F, 1'b0, 1'b0, 32'd0);
    send_poll(6'h3F, 4'hF, 5'h1F, 1'b0, 1'b0, 32'd349);
    send_poll(6'h3F, 4'hF, 5'h1F, 1'b0, 1'b0, 32'd350);
    send_poll(6'h3F, 4'hF, 5'h1F, 1'b0, 1'b0, 32'd399);
    send_poll(6'h3F, 4'hF, 5'h1F, 1'b0, 1'b0, 32'd400);
    send_poll('0, '0, '0, 1'b0, 1'b0, 32'd401);
    send_poll('0, '0, 5'b00001, 1'b0, 1'b0, 32'd402);
    send_poll('0, '0, 5'b00111, 1'b0, 1'b0, 32'd403);
    // text mode passes escape only and drops repeat state
    send_poll(6'h3F, 4'hF, 5'h18, 1'b1, 1'b0, 32'd404);
    send_poll(6'h3F, 4'hF, 5'h18, 1'b0, 1'b0, 32'd405);
    // blocked still stores levels
    send_poll('0, '0, '0, 1'b0, 1'b1, 32'd406);
    send_poll(6'h3F, 4'hF, 5'h1F, 1'b0, 1'b1, 32'd407);
    send_poll(6'h3F, 4'hF, 5'h1F, 1'b0, 1'b0, 32'd408);
    send_poll(6'h01, 4'hF, '0, 1'b1, 1'b1, 32'd409);
    // press just before the timestamp wraps
    send_poll('0, '0, '0, 1'b0, 1'b0, 32'hFFFF_FF00);
    send_poll('0, 4'b0101, '0, 1'b0, 1'b0, 32'hFFFF_FF00);
    send_poll('0, 4'b0101, '0, 1'b0, 1'b0, 32'h0000_0100);
    send_poll('0, 4'b0101, '0, 1'b0, 1'b0, 32'h0000_0131);
    send_poll('0, 4'b0101, '0, 1'b0, 1'b0, 32'h0000_0132);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       begin delay_v = DELAY_RST;               interval_v = INTERVAL_RST; end
        1:       begin delay_v = '0;                      interval_v = '0; end
        2:       begin delay_v = '1;                      interval_v = '1; end
        3:       begin delay_v = '0;                      interval_v = '1; end
        4:       begin delay_v = '1;                      interval_v = '0; end
        5:       begin
          delay_v    = CFG_W'($urandom_range(1, 400));
          interval_v = CFG_W'($urandom_range(1, 120));
        end
        6:       begin delay_v = CFG_W'($urandom);        interval_v = CFG_W'($urandom); end
        default: begin delay_v = DELAY_RST;               interval_v = INTERVAL_RST; end
      endcase
      if (phase != 0) begin
        write_reg(REG_DELAY, delay_v);
        write_reg(REG_INTERVAL, interval_v);
      end
      src_idle  = (phase == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      sink_idle = (phase == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      random_polls(POLLS_PER_PHASE, delay_v, interval_v);
    end

    drain_results();
    if (failures == 0)
      $display("key_edge_and_typematic_repeat verification clean");
    else
      $display("key_edge_and_typematic_repeat verification failed");
    $finish;
  end

endmodule
